FILE: rtl/core/ndv_pkg.sv
// Shared constants and register index codes for the node direction vector block.
// No dependencies; every other file of the block except ndv_vec imports this package.
package ndv_pkg;

	// The largest normalized magnitude is brought into [2^(NORM_TOP-1), 2^NORM_TOP).
	localparam int NORM_TOP   = 30;
	localparam int NORM_W     = NORM_TOP;
	localparam int SQ_W       = 2 * NORM_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int LEN_W      = NORM_TOP + 1;
	localparam int REM_W      = LEN_W + 1;
	localparam int ROOT_W     = SUM_W + 1;
	// The sum of squares stays below 2^62, so the root digits start at 4^30.
	localparam int SQRT_STEPS = SUM_W / 2;

	localparam int CFG_IDX_W  = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTR_X = 4'd0,
		REG_ATTR_Y = 4'd1,
		REG_ATTR_Z = 4'd2,
		REG_AXIS_X = 4'd3,
		REG_AXIS_Y = 4'd4,
		REG_AXIS_Z = 4'd5,
		REG_LINE   = 4'd6,
		REG_SCALE  = 4'd7
	} ndv_reg_t;

endpackage

FILE: rtl/core/ndv_vec.sv
// Vector formation pipeline: node minus attractor, line projection and raw vector.
// Standalone arithmetic; no package dependencies.
module ndv_vec #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] node [3],
	input  logic signed [COORD_WIDTH-1:0] node_value,
	input  logic signed [COORD_WIDTH-1:0] attr [3],
	input  logic signed [COORD_WIDTH-1:0] axis [3],
	input  logic                          line_mode,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH+1:0] vec [3],
	output logic signed [COORD_WIDTH-1:0] out_value
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int N  = 8;
	localparam int PW = 2 * W + 1;

	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W:0]   XMAX = {2'b00, {(W-1){1'b1}}};
	localparam logic signed [W:0]   XMIN = {2'b11, {(W-1){1'b0}}};

	// Fixed-point product finish: drop the fraction, clamp, apply the sign.
	function automatic logic signed [W-1:0] qfin(input logic [PW-1:0] p, input logic neg);
		logic [PW-1:0] sh;
		logic [PW-1:0] lim;
		sh  = p >> F;
		lim = PW'(1) << (W - 1);
		if (sh >= lim) begin
			qfin = neg ? SMIN : SMAX;
		end else begin
			qfin = neg ? -$signed(sh[W-1:0]) : $signed(sh[W-1:0]);
		end
	endfunction

	function automatic logic signed [W-1:0] satadd(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = $signed({a[W-1], a}) + $signed({b[W-1], b});
		if (s > XMAX) begin
			satadd = SMAX;
		end else if (s < XMIN) begin
			satadd = SMIN;
		end else begin
			satadd = s[W-1:0];
		end
	endfunction

	function automatic logic [W-1:0] magw(input logic signed [W-1:0] a);
		magw = a[W-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic [W:0] magd(input logic signed [W:0] a);
		magd = a[W] ? (~a + 1'b1) : a;
	endfunction

	logic [N:1] vld_s;
	logic [N:1] adv;
	logic [N:0] vchain;

	assign vchain = {vld_s, in_valid};

	// A stage may load when the output drains or it or any later stage holds a bubble.
	for (genvar k = 1; k <= N; k++) begin : g_adv
		assign adv[k] = out_ready | ~(&vld_s[N:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= N; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vchain[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_s[N];

	logic signed [W:0]   d_s1 [3], d_s2 [3], d_s3 [3], d_s4 [3], d_s5 [3], d_s6 [3], d_s7 [3];
	logic signed [W-1:0] val_s1, val_s2, val_s3, val_s4, val_s5, val_s6, val_s7, val_s8;
	logic [PW-1:0]       pp_s2 [3];
	logic [2:0]          pn_s2;
	logic signed [W-1:0] p_s3 [3];
	logic signed [W-1:0] a_s4, p2_s4;
	logic signed [W-1:0] dot_s5;
	logic [PW-1:0]       pr_s6 [3];
	logic [2:0]          prn_s6;
	logic signed [W-1:0] q_s7 [3];
	logic signed [W+1:0] v_s8 [3];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= $signed({node[i][W-1], node[i]}) - $signed({attr[i][W-1], attr[i]});
			end
			val_s1 <= node_value;
		end
		if (adv[2]) begin
			for (int i = 0; i < 3; i++) begin
				pp_s2[i] <= PW'(magw(axis[i])) * PW'(magd(d_s1[i]));
				pn_s2[i] <= axis[i][W-1] ^ d_s1[i][W];
			end
			d_s2   <= d_s1;
			val_s2 <= val_s1;
		end
		if (adv[3]) begin
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= qfin(pp_s2[i], pn_s2[i]);
			end
			d_s3   <= d_s2;
			val_s3 <= val_s2;
		end
		if (adv[4]) begin
			a_s4   <= satadd(p_s3[0], p_s3[1]);
			p2_s4  <= p_s3[2];
			d_s4   <= d_s3;
			val_s4 <= val_s3;
		end
		if (adv[5]) begin
			dot_s5 <= satadd(a_s4, p2_s4);
			d_s5   <= d_s4;
			val_s5 <= val_s4;
		end
		if (adv[6]) begin
			for (int i = 0; i < 3; i++) begin
				pr_s6[i]  <= PW'(magw(axis[i])) * PW'(magw(dot_s5));
				prn_s6[i] <= axis[i][W-1] ^ dot_s5[W-1];
			end
			d_s6   <= d_s5;
			val_s6 <= val_s5;
		end
		if (adv[7]) begin
			for (int i = 0; i < 3; i++) begin
				q_s7[i] <= qfin(pr_s6[i], prn_s6[i]);
			end
			d_s7   <= d_s6;
			val_s7 <= val_s6;
		end
		if (adv[8]) begin
			for (int i = 0; i < 3; i++) begin
				v_s8[i] <= line_mode
					? $signed({{2{q_s7[i][W-1]}}, q_s7[i]}) - $signed({d_s7[i][W], d_s7[i]})
					: -$signed({d_s7[i][W], d_s7[i]});
			end
			val_s8 <= val_s7;
		end
	end

	assign vec       = v_s8;
	assign out_value = val_s8;

endmodule

FILE: rtl/core/ndv_norm.sv
// Normalization pipeline: magnitudes, leading-one search, common shift, sum of squares.
// Depends on ndv_pkg for the normalized widths.
module ndv_norm #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH+1:0] vec [3],
	input  logic signed [COORD_WIDTH-1:0] in_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ndv_pkg::NORM_W-1:0]    nm [3],
	output logic [2:0]                    sgn,
	output logic                          zero,
	output logic signed [COORD_WIDTH-1:0] out_value,
	output logic [ndv_pkg::SUM_W-1:0]     sumsq
);

	import ndv_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int MW = W + 1;
	localparam int G  = (MW + 7) / 8;
	localparam int GW = G * 8;
	localparam int PW = $clog2(MW);
	localparam int NW = (MW > NORM_W) ? MW : NORM_W;
	localparam int N  = 6;
	localparam logic [PW-1:0] TOP_POS = PW'(NORM_TOP - 1);

	function automatic logic [2:0] msb8(input logic [7:0] b);
		logic [2:0] pos;
		pos = '0;
		for (int j = 0; j < 8; j++) begin
			if (b[j]) begin
				pos = 3'(j);
			end
		end
		msb8 = pos;
	endfunction

	logic [N:1] vld_s;
	logic [N:1] adv;
	logic [N:0] vchain;

	assign vchain = {vld_s, in_valid};

	for (genvar k = 1; k <= N; k++) begin : g_adv
		assign adv[k] = out_ready | ~(&vld_s[N:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= N; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vchain[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_s[N];

	logic [MW-1:0]       m_s1 [3], m_s2 [3], m_s3 [3];
	logic [2:0]          sg_s1, sg_s2, sg_s3, sg_s4, sg_s5, sg_s6;
	logic signed [W-1:0] val_s1, val_s2, val_s3, val_s4, val_s5, val_s6;
	logic [G-1:0]        gany_s2;
	logic [2:0]          gpos_s2 [G];
	logic [PW-1:0]       p_s3;
	logic                zero_s3, zero_s4, zero_s5, zero_s6;
	logic [NORM_W-1:0]   nm_s4 [3], nm_s5 [3], nm_s6 [3];
	logic [SQ_W-1:0]     sq_s5 [3];
	logic [SUM_W-1:0]    sum_s6;

	logic [GW-1:0]       orw;
	logic [PW-1:0]       msb_pos;
	logic [NORM_W-1:0]   nm_next [3];
	logic [NW-1:0]       mx [3];

	assign orw = GW'(m_s1[0] | m_s1[1] | m_s1[2]);

	// Highest nonzero group wins; its local position gives the leading one.
	always_comb begin
		msb_pos = '0;
		for (int g = 0; g < G; g++) begin
			if (gany_s2[g]) begin
				msb_pos = PW'(g * 8) + PW'(gpos_s2[g]);
			end
		end
	end

	// One common shift brings the largest magnitude to the top of the window.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mx[i] = NW'(m_s3[i]);
			if (p_s3 >= TOP_POS) begin
				nm_next[i] = NORM_W'(mx[i] >> (p_s3 - TOP_POS));
			end else begin
				nm_next[i] = NORM_W'(mx[i] << (TOP_POS - p_s3));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < 3; i++) begin
				m_s1[i]  <= vec[i][W+1] ? MW'(~vec[i] + 1'b1) : MW'(vec[i]);
				sg_s1[i] <= vec[i][W+1];
			end
			val_s1 <= in_value;
		end
		if (adv[2]) begin
			for (int g = 0; g < G; g++) begin
				gany_s2[g] <= |orw[g*8 +: 8];
				gpos_s2[g] <= msb8(orw[g*8 +: 8]);
			end
			m_s2   <= m_s1;
			sg_s2  <= sg_s1;
			val_s2 <= val_s1;
		end
		if (adv[3]) begin
			p_s3    <= msb_pos;
			zero_s3 <= ~|gany_s2;
			m_s3    <= m_s2;
			sg_s3   <= sg_s2;
			val_s3  <= val_s2;
		end
		if (adv[4]) begin
			nm_s4   <= nm_next;
			zero_s4 <= zero_s3;
			sg_s4   <= sg_s3;
			val_s4  <= val_s3;
		end
		if (adv[5]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= SQ_W'(nm_s4[i]) * SQ_W'(nm_s4[i]);
			end
			nm_s5   <= nm_s4;
			zero_s5 <= zero_s4;
			sg_s5   <= sg_s4;
			val_s5  <= val_s4;
		end
		if (adv[6]) begin
			sum_s6  <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
			nm_s6   <= nm_s5;
			zero_s6 <= zero_s5;
			sg_s6   <= sg_s5;
			val_s6  <= val_s5;
		end
	end

	assign nm        = nm_s6;
	assign sgn       = sg_s6;
	assign zero      = zero_s6;
	assign out_value = val_s6;
	assign sumsq     = sum_s6;

endmodule

FILE: rtl/core/ndv_sqrt.sv
// Pipelined integer square root, one result digit per stage, with a sideband carried along.
// Depends on ndv_pkg for the operand and root widths.
module ndv_sqrt #(
	parameter int SIDE_W = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ndv_pkg::SUM_W-1:0]  sumsq,
	input  logic [SIDE_W-1:0]          side_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ndv_pkg::LEN_W-1:0]  len,
	output logic [SIDE_W-1:0]          side_out
);

	import ndv_pkg::*;

	localparam int N = SQRT_STEPS;

	logic [N:1] vld_s;
	logic [N:1] adv;
	logic [N:0] vchain;

	assign vchain = {vld_s, in_valid};

	for (genvar k = 1; k <= N; k++) begin : g_adv
		assign adv[k] = out_ready | ~(&vld_s[N:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= N; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vchain[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_s[N];

	logic [SUM_W-1:0]  rem_s  [1:N];
	logic [ROOT_W-1:0] root_s [1:N];
	logic [SIDE_W-1:0] side_s [1:N];

	for (genvar k = 1; k <= N; k++) begin : g_step
		localparam logic [ROOT_W-1:0] DIGIT = ROOT_W'(1) << (2 * (N - k));
		logic [SUM_W-1:0]  rin;
		logic [ROOT_W-1:0] qin;
		logic [SIDE_W-1:0] sin;
		logic [ROOT_W-1:0] trial;
		logic              take;

		if (k == 1) begin : g_head
			assign rin = sumsq;
			assign qin = '0;
			assign sin = side_in;
		end else begin : g_body
			assign rin = rem_s[k-1];
			assign qin = root_s[k-1];
			assign sin = side_s[k-1];
		end

		assign trial = qin + DIGIT;
		assign take  = ROOT_W'(rin) >= trial;

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k]  <= take ? SUM_W'(ROOT_W'(rin) - trial) : rin;
				root_s[k] <= take ? ((qin >> 1) + DIGIT) : (qin >> 1);
				side_s[k] <= sin;
			end
		end
	end

	assign len      = LEN_W'(root_s[N]);
	assign side_out = side_s[N];

endmodule

FILE: rtl/core/ndv_div.sv
// Restoring divider lanes for the unit vector, then saturation, value scaling and output.
// Depends on ndv_pkg for the normalized, length and remainder widths.
module ndv_div #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ndv_pkg::LEN_W-1:0]     len,
	input  logic [ndv_pkg::NORM_W-1:0]    nm [3],
	input  logic [2:0]                    sgn,
	input  logic                          zero,
	input  logic signed [COORD_WIDTH-1:0] in_value,
	input  logic                          scale_by_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] result [3],
	output logic                          zero_length
);

	import ndv_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int D  = F + 1;
	localparam int N  = D + 3;
	localparam int QW = F + 1;
	localparam int CW = ((QW > W) ? QW : W) + 1;
	localparam int PW = 2 * W + 1;

	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [CW-1:0]       ULIM = CW'(1) << (W - 1);

	// Stand-in for a zero node value: 0.001 to the nearest step, at least one step.
	localparam int ZV_RAW = ((1 << F) + 500) / 1000;
	localparam int ZV_INT = (ZV_RAW == 0) ? 1 : ZV_RAW;
	localparam logic signed [W-1:0] ZVAL = W'(ZV_INT);

	function automatic logic signed [W-1:0] qfin(input logic [PW-1:0] p, input logic neg);
		logic [PW-1:0] sh;
		logic [PW-1:0] lim;
		sh  = p >> F;
		lim = PW'(1) << (W - 1);
		if (sh >= lim) begin
			qfin = neg ? SMIN : SMAX;
		end else begin
			qfin = neg ? -$signed(sh[W-1:0]) : $signed(sh[W-1:0]);
		end
	endfunction

	function automatic logic [W-1:0] magw(input logic signed [W-1:0] a);
		magw = a[W-1] ? (~a + 1'b1) : a;
	endfunction

	logic [N:1] vld_s;
	logic [N:1] adv;
	logic [N:0] vchain;

	assign vchain = {vld_s, in_valid};

	for (genvar k = 1; k <= N; k++) begin : g_adv
		assign adv[k] = out_ready | ~(&vld_s[N:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= N; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vchain[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_s[N];

	// Divider stages: one quotient bit per stage in each of the three lanes.
	logic [REM_W-1:0]    rem_s  [1:D][3];
	logic [QW-1:0]       quo_s  [1:D][3];
	logic [LEN_W-1:0]    len_s  [1:D];
	logic [2:0]          sg_s   [1:D];
	logic                zero_s [1:D];
	logic signed [W-1:0] val_s  [1:D];

	for (genvar k = 1; k <= D; k++) begin : g_step
		logic [REM_W-1:0]    rin  [3];
		logic [QW-1:0]       qin  [3];
		logic [LEN_W-1:0]    lin;
		logic [2:0]          sgin;
		logic                zin;
		logic signed [W-1:0] vin;
		logic [REM_W-1:0]    rnext [3];
		logic [QW-1:0]       qnext [3];

		if (k == 1) begin : g_head
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rin[i] = REM_W'(nm[i]);
				assign qin[i] = '0;
			end
			assign lin  = len;
			assign sgin = sgn;
			assign zin  = zero;
			assign vin  = in_value;
		end else begin : g_body
			assign rin  = rem_s[k-1];
			assign qin  = quo_s[k-1];
			assign lin  = len_s[k-1];
			assign sgin = sg_s[k-1];
			assign zin  = zero_s[k-1];
			assign vin  = val_s[k-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				if (rin[i] >= REM_W'(lin)) begin
					rnext[i] = (rin[i] - REM_W'(lin)) << 1;
					qnext[i] = {qin[i][QW-2:0], 1'b1};
				end else begin
					rnext[i] = rin[i] << 1;
					qnext[i] = {qin[i][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k]  <= rnext;
				quo_s[k]  <= qnext;
				len_s[k]  <= lin;
				sg_s[k]   <= sgin;
				zero_s[k] <= zin;
				val_s[k]  <= vin;
			end
		end
	end

	// Tail stages: saturate and sign, multiply by the value, select and clear.
	logic signed [W-1:0] unit_s1 [3], unit_s2 [3];
	logic signed [W-1:0] eval_s1;
	logic                zero_s1, zero_s2, zero_s3;
	logic [PW-1:0]       prod_s2 [3];
	logic [2:0]          neg_s2;
	logic signed [W-1:0] res_s3 [3];

	logic [CW-1:0]       qx [3];
	logic signed [W-1:0] unit_next [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qx[i] = CW'(quo_s[D][i]);
			if (!sg_s[D][i]) begin
				unit_next[i] = (qx[i] >= ULIM) ? SMAX : $signed(W'(qx[i]));
			end else begin
				unit_next[i] = (qx[i] > ULIM) ? SMIN : -$signed(W'(qx[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[D+1]) begin
			unit_s1 <= unit_next;
			eval_s1 <= (val_s[D] == '0) ? ZVAL : val_s[D];
			zero_s1 <= zero_s[D];
		end
		if (adv[D+2]) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= PW'(magw(unit_s1[i])) * PW'(magw(eval_s1));
				neg_s2[i]  <= unit_s1[i][W-1] ^ eval_s1[W-1];
			end
			unit_s2 <= unit_s1;
			zero_s2 <= zero_s1;
		end
		if (adv[D+3]) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_s2) begin
					res_s3[i] <= '0;
				end else if (scale_by_value) begin
					res_s3[i] <= qfin(prod_s2[i], neg_s2[i]);
				end else begin
					res_s3[i] <= unit_s2[i];
				end
			end
			zero_s3 <= zero_s2;
		end
	end

	assign result      = res_s3;
	assign zero_length = zero_s3;

endmodule

FILE: rtl/core/node_direction_vector.sv
// Top level of the node direction vector block: configuration registers and pipeline.
// Depends on ndv_pkg, ndv_vec, ndv_norm, ndv_sqrt and ndv_div.

// Per-node direction generator. Each transfer on the input channel carries one mesh node
// position and its scalar value; each transfer on the output channel carries the matching
// unit vector (optionally scaled by the value) and a flag for a zero-length vector, in
// input order. The block is a fully pipelined datapath that takes one node every clock
// cycle unless every stage is full and the output is stalled; its depth is 8 vector
// stages, 6 normalization stages, 31 square-root digit stages, FRACTION_BITS + 1 divider
// stages and 3 scaling stages. Every stage has its own valid bit, and a stage loads
// whenever it or some later stage holds a bubble, so a result waiting at the output
// never blocks new nodes while the pipeline has room. Configuration registers are
// written through the cfg channel, which is always ready; they must only be changed
// while no node is in flight.
module node_direction_vector #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       node_x,
	input  logic signed [COORD_WIDTH-1:0]       node_y,
	input  logic signed [COORD_WIDTH-1:0]       node_z,
	input  logic signed [COORD_WIDTH-1:0]       node_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [COORD_WIDTH-1:0]       result_x,
	output logic signed [COORD_WIDTH-1:0]       result_y,
	output logic signed [COORD_WIDTH-1:0]       result_z,
	output logic                                zero_length,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ndv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_data
);

	import ndv_pkg::*;

	localparam int W      = COORD_WIDTH;
	localparam int SIDE_W = W + 1 + 3 + 3 * NORM_W;

	// Configuration registers. Writes to an index past the list are dropped.
	logic signed [W-1:0] attr_q [3];
	logic signed [W-1:0] axis_q [3];
	logic                line_q;
	logic                scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q  <= '{default: '0};
			axis_q  <= '{default: '0};
			line_q  <= 1'b0;
			scale_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (ndv_reg_t'(cfg_index))
				REG_ATTR_X: begin
					attr_q[0] <= cfg_data;
				end
				REG_ATTR_Y: begin
					attr_q[1] <= cfg_data;
				end
				REG_ATTR_Z: begin
					attr_q[2] <= cfg_data;
				end
				REG_AXIS_X: begin
					axis_q[0] <= cfg_data;
				end
				REG_AXIS_Y: begin
					axis_q[1] <= cfg_data;
				end
				REG_AXIS_Z: begin
					axis_q[2] <= cfg_data;
				end
				REG_LINE: begin
					line_q <= cfg_data[0];
				end
				REG_SCALE: begin
					scale_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	logic signed [W-1:0] node_v [3];

	assign node_v[0] = node_x;
	assign node_v[1] = node_y;
	assign node_v[2] = node_z;

	// Vector formation: in point mode the vector is attractor minus node; in line mode
	// it is axis times (axis dot diff) minus diff, which points at the line.
	logic                vec_valid, vec_ready;
	logic signed [W+1:0] vec_v [3];
	logic signed [W-1:0] vec_value;

	ndv_vec #(
		.COORD_WIDTH  (COORD_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.node      (node_v),
		.node_value(node_value),
		.attr      (attr_q),
		.axis      (axis_q),
		.line_mode (line_q),
		.out_valid (vec_valid),
		.out_ready (vec_ready),
		.vec       (vec_v),
		.out_value (vec_value)
	);

	// Normalization: the largest magnitude is shifted into the top window so the
	// square root and division work on fixed widths whatever the vector's size.
	logic                norm_valid, norm_ready;
	logic [NORM_W-1:0]   norm_m [3];
	logic [2:0]          norm_sgn;
	logic                norm_zero;
	logic signed [W-1:0] norm_value;
	logic [SUM_W-1:0]    norm_sum;

	ndv_norm #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vec_valid),
		.in_ready (vec_ready),
		.vec      (vec_v),
		.in_value (vec_value),
		.out_valid(norm_valid),
		.out_ready(norm_ready),
		.nm       (norm_m),
		.sgn      (norm_sgn),
		.zero     (norm_zero),
		.out_value(norm_value),
		.sumsq    (norm_sum)
	);

	// The magnitudes, signs, zero flag and value ride alongside the root.
	logic              sq_valid, sq_ready;
	logic [LEN_W-1:0]  sq_len;
	logic [SIDE_W-1:0] side_in, side_out;
	logic [NORM_W-1:0]   sq_m [3];
	logic [2:0]          sq_sgn;
	logic                sq_zero;
	logic signed [W-1:0] sq_value;

	assign side_in = {norm_value, norm_zero, norm_sgn, norm_m[2], norm_m[1], norm_m[0]};
	assign {sq_value, sq_zero, sq_sgn, sq_m[2], sq_m[1], sq_m[0]} = side_out;

	ndv_sqrt #(
		.SIDE_W(SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (norm_valid),
		.in_ready (norm_ready),
		.sumsq    (norm_sum),
		.side_in  (side_in),
		.out_valid(sq_valid),
		.out_ready(sq_ready),
		.len      (sq_len),
		.side_out (side_out)
	);

	// Division by the length, saturation, optional scaling and the output register.
	logic signed [W-1:0] res_v [3];

	ndv_div #(
		.COORD_WIDTH  (COORD_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (sq_valid),
		.in_ready      (sq_ready),
		.len           (sq_len),
		.nm            (sq_m),
		.sgn           (sq_sgn),
		.zero          (sq_zero),
		.in_value      (sq_value),
		.scale_by_value(scale_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result        (res_v),
		.zero_length   (zero_length)
	);

	assign result_x = res_v[0];
	assign result_y = res_v[1];
	assign result_z = res_v[2];

	// A zero-length vector must come out as the zero vector, scaled or not.
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> result_x == '0 && result_y == '0 && result_z == '0)
		else $error("zero-length result carries a nonzero component");

	// The input may only back up when every stage is full and the output is stalled.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while the pipeline had room");

endmodule

FILE: bench/node_direction_vector_tb.sv
// Self-checking testbench for the node direction vector block.
// Depends on ndv_pkg and node_direction_vector; holds its own predictor and scoreboard.
`timescale 1ns / 1ps

typedef struct {
	logic signed [31:0] x;
	logic signed [31:0] y;
	logic signed [31:0] z;
	logic               zl;
} dir_result_t;

// Predicts each direction vector from the node and a private copy of the
// registers, and matches results against the oldest pending prediction.
class dir_scoreboard;
	localparam int FRAC = 16;
	localparam longint LIM = 64'sd1 << 31;
	localparam longint TINY_VALUE = ((64'sd1 << FRAC) + 500) / 1000;

	longint attr[3];
	longint axis[3];
	bit line_mode;
	bit scale_on;
	dir_result_t pending_dirs[$];
	int errors;

	function new();
		attr = '{0, 0, 0};
		axis = '{0, 0, 0};
		line_mode = 0;
		scale_on = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [3:0] idx, logic [31:0] data);
		case (idx)
			ndv_pkg::REG_ATTR_X: attr[0] = longint'($signed(data));
			ndv_pkg::REG_ATTR_Y: attr[1] = longint'($signed(data));
			ndv_pkg::REG_ATTR_Z: attr[2] = longint'($signed(data));
			ndv_pkg::REG_AXIS_X: axis[0] = longint'($signed(data));
			ndv_pkg::REG_AXIS_Y: axis[1] = longint'($signed(data));
			ndv_pkg::REG_AXIS_Z: axis[2] = longint'($signed(data));
			ndv_pkg::REG_LINE:   line_mode = data[0];
			ndv_pkg::REG_SCALE:  scale_on = data[0];
			default: ;
		endcase
	endfunction

	function longint clamp(longint v);
		if (v >= LIM) return LIM - 1;
		if (v < -LIM) return -LIM;
		return v;
	endfunction

	function longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// Fixed-point product: magnitude truncated toward zero, then saturated.
	function longint fx_mul(longint a, longint b);
		logic [127:0] prod;
		logic [127:0] shifted;
		bit neg;
		neg = (a < 0) != (b < 0);
		prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		shifted = prod >> FRAC;
		if (shifted >= 128'(LIM)) return neg ? -LIM : LIM - 1;
		return neg ? -longint'(shifted[63:0]) : longint'(shifted[63:0]);
	endfunction

	function longint unsigned int_sqrt(longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function dir_result_t predict(logic signed [31:0] nx, logic signed [31:0] ny,
			logic signed [31:0] nz, logic signed [31:0] nval);
		longint node[3];
		longint v[3];
		longint diff[3];
		longint dot;
		longint unsigned m[3];
		longint unsigned big;
		longint unsigned len;
		longint unsigned q;
		longint res[3];
		longint val;
		dir_result_t r;
		node = '{longint'(nx), longint'(ny), longint'(nz)};
		if (line_mode) begin
			dot = 0;
			for (int i = 0; i < 3; i++) begin
				diff[i] = node[i] - attr[i];
				dot = clamp(dot + fx_mul(axis[i], diff[i]));
			end
			for (int i = 0; i < 3; i++) v[i] = fx_mul(axis[i], dot) - diff[i];
		end else begin
			for (int i = 0; i < 3; i++) v[i] = attr[i] - node[i];
		end
		big = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = magnitude(v[i]);
			if (m[i] > big) big = m[i];
		end
		r.zl = (big == 0);
		res = '{0, 0, 0};
		if (!r.zl) begin
			// Bring the largest magnitude into [2^29, 2^30) before the root.
			while (big >= (64'd1 << 30)) begin
				big = big >> 1;
				for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
			end
			while (big < (64'd1 << 29)) begin
				big = big << 1;
				for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			end
			len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
			for (int i = 0; i < 3; i++) begin
				q = (m[i] << FRAC) / len;
				res[i] = (v[i] < 0) ? clamp(-longint'(q)) : clamp(longint'(q));
			end
			if (scale_on) begin
				val = longint'(nval);
				if (val == 0) val = (TINY_VALUE == 0) ? 1 : TINY_VALUE;
				for (int i = 0; i < 3; i++) res[i] = fx_mul(res[i], val);
			end
		end
		r.x = res[0][31:0];
		r.y = res[1][31:0];
		r.z = res[2][31:0];
		return r;
	endfunction

	function void note_node(logic signed [31:0] nx, logic signed [31:0] ny,
			logic signed [31:0] nz, logic signed [31:0] nval);
		pending_dirs.push_back(predict(nx, ny, nz, nval));
	endfunction

	function void check_result(dir_result_t got);
		dir_result_t want;
		if (pending_dirs.size() == 0) begin
			errors++;
			if (errors <= 10) $display("ERROR: unexpected result %h %h %h zl=%b",
				got.x, got.y, got.z, got.zl);
			return;
		end
		want = pending_dirs.pop_front();
		if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
				got.zl !== want.zl) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: exp %h %h %h zl=%b, got %h %h %h zl=%b",
					want.x, want.y, want.z, want.zl, got.x, got.y, got.z, got.zl);
		end
	endfunction
endclass

module node_direction_vector_tb;
	import ndv_pkg::*;

	// Idle period held after the last pending result has come back, and the node count
	// of each random phase.
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 160;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] node_x;
	logic signed [31:0] node_y;
	logic signed [31:0] node_z;
	logic signed [31:0] node_value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] result_x;
	logic signed [31:0] result_y;
	logic signed [31:0] result_z;
	logic               zero_length;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]        cfg_data;

	dir_scoreboard sb = new();

	// Burst shaping of the sender: items left in the current burst.
	int burst_left;
	// Receiver stall pattern mode and a cycle counter that drives it.
	int stall_mode;
	int stall_cnt;

	node_direction_vector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.node_x(node_x), .node_y(node_y), .node_z(node_z), .node_value(node_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_x(result_x), .result_y(result_y), .result_z(result_z),
		.zero_length(zero_length),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#1000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Every accepted result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{result_x, result_y, result_z, zero_length});
	end

	// The receiver switches between free flow, light and heavy random stalls and a periodic
	// stall pattern so that stalls land on all pipeline phases.
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 9) < 7);
			2: out_ready <= (stall_cnt % 7) < 3;
			default: out_ready <= ($urandom_range(0, 9) < 2);
		endcase
	end

	// Register write over the configuration channel; only used while idle.
	// Valid is dropped after each write transfer before the task returns.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, data);
		@(posedge clk);
	endtask

	// Sends one node. Between bursts the valid may be dropped for a random gap;
	// inside a burst it stays high and only the payload moves on.
	task automatic send_node(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
			logic [31:0] nval);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		node_x     <= nx;
		node_y     <= ny;
		node_z     <= nz;
		node_value <= nval;
		do @(posedge clk); while (!in_ready);
		sb.note_node(nx, ny, nz, nval);
	endtask

	// Drops valid and waits until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending_dirs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Coordinate mix: extremes, zero, small values and full-range values.
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3, 4: return $urandom_range(0, 1 << 21) - (1 << 20);
			default: return $urandom;
		endcase
	endfunction

	task automatic set_phase(int p);
		case (p)
			1: begin
				write_reg(REG_ATTR_X, $urandom);
				write_reg(REG_ATTR_Y, $urandom_range(0, 65535) << 8);
				write_reg(REG_ATTR_Z, 32'hffff0000);
				write_reg(REG_SCALE, 1);
			end
			2: begin
				// Unit axis along x: nodes displaced only in x lie on the line.
				write_reg(REG_AXIS_X, 32'h00010000);
				write_reg(REG_AXIS_Y, 0);
				write_reg(REG_AXIS_Z, 0);
				write_reg(REG_LINE, 1);
				write_reg(REG_SCALE, 0);
			end
			3: begin
				write_reg(REG_AXIS_X, $urandom_range(0, 1 << 17) - (1 << 16));
				write_reg(REG_AXIS_Y, $urandom_range(0, 1 << 17) - (1 << 16));
				write_reg(REG_AXIS_Z, $urandom_range(0, 1 << 17) - (1 << 16));
				write_reg(REG_SCALE, 1);
			end
			4: begin
				write_reg(REG_ATTR_X, 32'h7fffffff);
				write_reg(REG_ATTR_Y, 32'h80000000);
				write_reg(REG_ATTR_Z, 32'h7fffffff);
				write_reg(REG_AXIS_X, 32'h7fffffff);
				write_reg(REG_AXIS_Y, 32'h80000000);
				write_reg(REG_AXIS_Z, $urandom);
			end
			5: begin
				// Zero axis: line mode collapses onto the point direction.
				write_reg(REG_AXIS_X, 0);
				write_reg(REG_AXIS_Y, 0);
				write_reg(REG_AXIS_Z, 0);
				write_reg(REG_SCALE, 0);
			end
			6: begin
				write_reg(REG_LINE, 0);
				write_reg(REG_SCALE, 1);
				write_reg(REG_ATTR_X, 32'h80000000);
				write_reg(REG_ATTR_Y, 32'h80000000);
				write_reg(REG_ATTR_Z, 32'h80000000);
				// An index past the register file must leave everything alone.
				write_reg(4'd11, 32'hdeadbeef);
			end
			default: begin
				for (int r = REG_ATTR_X; r <= REG_AXIS_Z; r++)
					write_reg(r[CFG_IDX_W-1:0], $urandom);
				write_reg(REG_LINE, $urandom_range(0, 1));
				write_reg(REG_SCALE, $urandom_range(0, 1));
			end
		endcase
	endtask

	task automatic random_nodes(int count);
		logic [31:0] c[3];
		logic [31:0] val;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 3; i++) c[i] = pick_coord();
			case ($urandom_range(0, 19))
				// Node on the attractor: zero-length vector.
				0: for (int i = 0; i < 3; i++) c[i] = sb.attr[i][31:0];
				// Node on the attractor shifted along x, on the line for a unit x axis.
				1: begin
					c[0] = sb.attr[0][31:0] + ($urandom_range(0, 1 << 20) - (1 << 19));
					c[1] = sb.attr[1][31:0];
					c[2] = sb.attr[2][31:0];
				end
				// Node near the attractor.
				2, 3: for (int i = 0; i < 3; i++)
					c[i] = sb.attr[i][31:0] + ($urandom_range(0, 64) - 32);
				default: ;
			endcase
			val = ($urandom_range(0, 9) == 0) ? 32'h0 : pick_coord();
			send_node(c[0], c[1], c[2], val);
			// Once in a while the sender holds off until the pipeline is empty.
			if (n == count / 2 && $urandom_range(0, 1) == 0) drain();
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		node_x     = '0;
		node_y     = '0;
		node_z     = '0;
		node_value = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		out_ready  = 1'b0;
		stall_mode = 0;
		stall_cnt  = 1;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset settings: attractor at the origin, point mode.
		send_node(0, 0, 0, 0);
		send_node(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
		send_node(32'h80000000, 32'h80000000, 32'h80000000, 0);
		send_node(32'h80000000, 0, 0, 0);
		send_node(32'h7fffffff, 32'h80000000, 1, 0);
		send_node(1, 0, 0, 0);
		send_node(32'hffffffff, 1, 32'hffffffff, 0);
		send_node(32'h00010000, 32'h00010000, 0, 0);
		drain();
		write_reg(REG_SCALE, 1);
		// Scaling: a zero value becomes the small substitute, extremes saturate.
		send_node(32'h00010000, 0, 0, 0);
		send_node(32'h00010000, 0, 0, 32'h7fffffff);
		send_node(32'h80000000, 0, 0, 32'h80000000);
		send_node(32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h00020000);
		send_node(0, 0, 0, 32'h7fffffff);
		send_node(3, 32'hfffffffd, 5, 32'hffff0000);
		drain();
		write_reg(REG_LINE, 1);
		// Line mode with a zero axis points at the attractor.
		send_node(32'h00050000, 32'hfffb0000, 32'h00010000, 0);
		send_node(0, 0, 0, 0);
		send_node(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h00008000);
		drain();
		write_reg(REG_LINE, 0);
		write_reg(REG_SCALE, 0);

		random_nodes(RANDOM_PER_PHASE);
		for (int p = 1; p <= 7; p++) begin
			drain();
			set_phase(p);
			random_nodes(RANDOM_PER_PHASE);
		end

		in_valid <= 1'b0;
		while (sb.pending_dirs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.errors += sb.pending_dirs.size();
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
